>>> rtl/graph_coloring_conflict_tracker_unit_macros.svh
// ----------------------------------------------------------------------------
// Graph coloring conflict tracker assertion macros
// Concurrent assertion shorthands clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef GRAPH_COLORING_CONFLICT_TRACKER_UNIT_MACROS_SVH
`define GRAPH_COLORING_CONFLICT_TRACKER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define GCCT_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("gcct: invariant violated");
`define GCCT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gcct: implication violated");
`define GCCT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gcct: next-cycle implication violated");
`else
`define GCCT_ASSERT_ALWAYS(lbl, expr)
`define GCCT_ASSERT_IMP(lbl, ante, cons)
`define GCCT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/gcct_pkg.sv
// ----------------------------------------------------------------------------
// Graph coloring conflict tracker package
// Sizes, operation and status codes, and saturating counter helpers.
// ----------------------------------------------------------------------------
package gcct_pkg;

  localparam int VERTICES   = 256;
  localparam int VTX_W      = 8;
  localparam int MAX_DEGREE = 16;
  localparam int DEG_W      = 5;
  localparam int SLOT_W     = 4;
  localparam int MAX_COLORS = 16;
  localparam int COLOR_W    = 4;
  localparam int COUNT_W    = 5;
  localparam int TAB_AW     = VTX_W + COLOR_W;
  localparam int ADJ_AW     = VTX_W + SLOT_W;
  localparam int EDGE_W     = 12;
  localparam int CVT_W      = 9;
  localparam int RAW_W      = 13;
  localparam int NCOL_W     = 5;
  localparam int IN_W       = 24;
  localparam int OUT_W      = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;
  localparam logic [EDGE_W-1:0]  EDGE_MAX  = 12'd4095;
  localparam logic [DEG_W-1:0]   DEG_FULL  = 5'd16;
  localparam logic [NCOL_W-1:0]  NCOL_RESET = 5'd4;

  typedef enum logic [2:0] {
    OP_ADD_EDGE = 3'd0,
    OP_SET      = 3'd1,
    OP_REBUILD  = 3'd2,
    OP_MOVE     = 3'd3,
    OP_QUERY    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_t;

  function automatic logic [COUNT_W-1:0] count_inc(input logic [COUNT_W-1:0] x);
    return (x == COUNT_MAX) ? x : x + 5'd1;
  endfunction

  function automatic logic [COUNT_W-1:0] count_dec(input logic [COUNT_W-1:0] x);
    return (x == '0) ? x : x - 5'd1;
  endfunction

endpackage

>>> rtl/graph_coloring_conflict_tracker_unit.sv
// ----------------------------------------------------------------------------
// Graph coloring conflict tracker
// Adjacency lists, vertex colors and a per-vertex neighbour color count table
// held in synchronous RAMs, updated by a read-modify-write sequencer.
// ----------------------------------------------------------------------------
// Add edge, set color and query run straight from dispatch to the result capture.
// Move: walks the moved vertex's list, with a conflict walk over the list of
// each neighbour that held the old color, then one over the moved vertex's own list.
// Rebuild: clears and refills each vertex's count row from its list; one item at a time.
// Reset: a clearing pass zeroes the color, degree, flag and count RAMs; no
// input transfer is taken until it ends.
// ----------------------------------------------------------------------------
`include "graph_coloring_conflict_tracker_unit_macros.svh"

module graph_coloring_conflict_tracker_unit (
  input  logic        clk,
  input  logic        rst,
  // s_tdata: operation[2:0], vertex[10:3], neighbour[18:11], color[22:19]
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,
  // m_tdata: status[1:0], conflict_edges[13:2], vertex_in_conflict[14],
  // coloring_valid[15], neighbours_of_color[20:16], previous_color[24:21]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data
);

  // One-hot sequencer states. Each RAM read is issued in one state and its
  // data is consumed in the state that directly follows.
  typedef enum logic [33:0] {
    ST_CLEAR    = 34'd1 << 0,
    ST_IDLE     = 34'd1 << 1,
    ST_START    = 34'd1 << 2,
    ST_DISPATCH = 34'd1 << 3,
    ST_R_START  = 34'd1 << 4,
    ST_R_CAP    = 34'd1 << 5,
    ST_R_CLR    = 34'd1 << 6,
    ST_R_WALK   = 34'd1 << 7,
    ST_R_ADJ    = 34'd1 << 8,
    ST_R_COL    = 34'd1 << 9,
    ST_R_TAB    = 34'd1 << 10,
    ST_R_FLAG   = 34'd1 << 11,
    ST_M_LOOP   = 34'd1 << 12,
    ST_M_ADJ    = 34'd1 << 13,
    ST_M_COL    = 34'd1 << 14,
    ST_M_UP     = 34'd1 << 15,
    ST_M_DN     = 34'd1 << 16,
    ST_M_CHK    = 34'd1 << 17,
    ST_M_WDONE  = 34'd1 << 18,
    ST_M_CLR    = 34'd1 << 19,
    ST_M_NEW    = 34'd1 << 20,
    ST_M_SET    = 34'd1 << 21,
    ST_M_SDONE  = 34'd1 << 22,
    ST_M_SFLAG  = 34'd1 << 23,
    ST_W_START  = 34'd1 << 24,
    ST_W_CAP    = 34'd1 << 25,
    ST_W_LOOP   = 34'd1 << 26,
    ST_W_ADJ    = 34'd1 << 27,
    ST_W_CMP    = 34'd1 << 28,
    ST_F_COL    = 34'd1 << 29,
    ST_F_OWN    = 34'd1 << 30,
    ST_F_QRY    = 34'd1 << 31,
    ST_F_CAP    = 34'd1 << 32,
    ST_DONE     = 34'd1 << 33
  } state_t;

  state_t state, state_next;

  // Configuration and the two running totals.
  logic [gcct_pkg::NCOL_W-1:0]  num_colors;
  logic [gcct_pkg::CVT_W-1:0]   cvt;
  logic [gcct_pkg::EDGE_W-1:0]  cet;
  logic [gcct_pkg::TAB_AW-1:0]  clr;

  // Current item.
  logic [2:0]                   op;
  logic [gcct_pkg::VTX_W-1:0]   v;
  logic [gcct_pkg::VTX_W-1:0]   nb;
  logic [gcct_pkg::COLOR_W-1:0] c;
  logic [1:0]                   status;
  logic [gcct_pkg::COLOR_W-1:0] prev;
  logic [gcct_pkg::DEG_W-1:0]   degv;
  logic                         c_ok;

  // Rebuild walk.
  logic [gcct_pkg::VTX_W-1:0]   rv;
  logic [gcct_pkg::DEG_W-1:0]   rdeg;
  logic [gcct_pkg::COLOR_W-1:0] rcol;
  logic [gcct_pkg::SLOT_W-1:0]  k;
  logic                         flag;
  logic [gcct_pkg::RAW_W-1:0]   raw;

  // Move walk.
  logic [gcct_pkg::DEG_W-1:0]   d;
  logic [gcct_pkg::VTX_W-1:0]   w;
  logic [gcct_pkg::COLOR_W-1:0] colw;

  // Conflict walk over one vertex's list, shared by the move steps.
  logic [gcct_pkg::VTX_W-1:0]   wx;
  logic [gcct_pkg::DEG_W-1:0]   wdeg;
  logic [gcct_pkg::COLOR_W-1:0] wcol;
  logic [gcct_pkg::DEG_W-1:0]   e;
  logic                         wres;
  logic                         walk_self;
  state_t                       walk_ret;

  // Result capture.
  logic                         own_nz;
  logic [gcct_pkg::COUNT_W-1:0] nc;
  logic                         out_free;

  // RAM ports.
  logic                         col_we;
  logic [gcct_pkg::VTX_W-1:0]   col_waddr, col_raddr;
  logic [gcct_pkg::COLOR_W-1:0] col_wdata, col_rdata;
  logic                         deg_we;
  logic [gcct_pkg::VTX_W-1:0]   deg_waddr, deg_raddr;
  logic [gcct_pkg::DEG_W-1:0]   deg_wdata, deg_rdata;
  logic                         adj_we;
  logic [gcct_pkg::ADJ_AW-1:0]  adj_waddr, adj_raddr;
  logic [gcct_pkg::VTX_W-1:0]   adj_wdata, adj_rdata;
  logic                         tab_we;
  logic [gcct_pkg::TAB_AW-1:0]  tab_waddr, tab_raddr;
  logic [gcct_pkg::COUNT_W-1:0] tab_wdata, tab_rdata;
  logic                         flg_we;
  logic [gcct_pkg::VTX_W-1:0]   flg_waddr, flg_raddr;
  logic                         flg_wdata, flg_rdata;

  gcct_ram #(.WIDTH(gcct_pkg::COLOR_W), .DEPTH(gcct_pkg::VERTICES)) u_colors (
    .clk(clk), .we(col_we), .waddr(col_waddr), .wdata(col_wdata),
    .raddr(col_raddr), .rdata(col_rdata)
  );

  gcct_ram #(.WIDTH(gcct_pkg::DEG_W), .DEPTH(gcct_pkg::VERTICES)) u_degree (
    .clk(clk), .we(deg_we), .waddr(deg_waddr), .wdata(deg_wdata),
    .raddr(deg_raddr), .rdata(deg_rdata)
  );

  gcct_ram #(.WIDTH(gcct_pkg::VTX_W), .DEPTH(gcct_pkg::VERTICES * gcct_pkg::MAX_DEGREE))
    u_adjacency (
    .clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
    .raddr(adj_raddr), .rdata(adj_rdata)
  );

  gcct_ram #(.WIDTH(gcct_pkg::COUNT_W), .DEPTH(gcct_pkg::VERTICES * gcct_pkg::MAX_COLORS))
    u_count_table (
    .clk(clk), .we(tab_we), .waddr(tab_waddr), .wdata(tab_wdata),
    .raddr(tab_raddr), .rdata(tab_rdata)
  );

  gcct_ram #(.WIDTH(1), .DEPTH(gcct_pkg::VERTICES)) u_flags (
    .clk(clk), .we(flg_we), .waddr(flg_waddr), .wdata(flg_wdata),
    .raddr(flg_raddr), .rdata(flg_rdata)
  );

  // A color is legal when it is below min(num_colors, 16); with a 4-bit color
  // that reduces to a plain compare against the register.
  assign c_ok     = ({1'b0, c} < num_colors);
  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign walk_ret = walk_self ? ST_M_SDONE : ST_M_WDONE;

  // Sequencer: next state and RAM port control.
  always_comb begin
    state_next = state;
    col_we = 1'b0; col_waddr = v; col_wdata = c; col_raddr = v;
    deg_we = 1'b0; deg_waddr = v; deg_wdata = deg_rdata + 5'd1; deg_raddr = v;
    adj_we = 1'b0; adj_waddr = {v, deg_rdata[gcct_pkg::SLOT_W-1:0]}; adj_wdata = nb;
    adj_raddr = {v, d[gcct_pkg::SLOT_W-1:0]};
    tab_we = 1'b0; tab_waddr = {v, c}; tab_wdata = '0; tab_raddr = {v, c};
    flg_we = 1'b0; flg_waddr = w; flg_wdata = 1'b0; flg_raddr = w;

    unique case (state)
      ST_CLEAR: begin
        col_we = 1'b1; col_waddr = clr[gcct_pkg::VTX_W-1:0]; col_wdata = '0;
        deg_we = 1'b1; deg_waddr = clr[gcct_pkg::VTX_W-1:0]; deg_wdata = '0;
        flg_we = 1'b1; flg_waddr = clr[gcct_pkg::VTX_W-1:0]; flg_wdata = 1'b0;
        tab_we = 1'b1; tab_waddr = clr; tab_wdata = '0;
        if (clr == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_START;
        end
      end
      ST_START: begin
        col_raddr = v;
        deg_raddr = v;
        state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        state_next = ST_F_COL;
        unique case (op)
          gcct_pkg::OP_ADD_EDGE: begin
            if (deg_rdata < gcct_pkg::DEG_FULL) begin
              adj_we = 1'b1;
              deg_we = 1'b1;
            end
          end
          gcct_pkg::OP_SET: begin
            col_we = c_ok;
          end
          gcct_pkg::OP_REBUILD: begin
            state_next = ST_R_START;
          end
          gcct_pkg::OP_MOVE: begin
            if (c_ok) begin
              col_we = 1'b1;
              state_next = ST_M_LOOP;
            end
          end
          default: begin
            state_next = ST_F_COL;
          end
        endcase
      end
      ST_R_START: begin
        col_raddr = rv;
        deg_raddr = rv;
        state_next = ST_R_CAP;
      end
      ST_R_CAP: begin
        state_next = ST_R_CLR;
      end
      ST_R_CLR: begin
        tab_we = 1'b1; tab_waddr = {rv, k}; tab_wdata = '0;
        if (k == '1) begin
          state_next = ST_R_WALK;
        end
      end
      ST_R_WALK: begin
        adj_raddr = {rv, d[gcct_pkg::SLOT_W-1:0]};
        state_next = (d == rdeg) ? ST_R_FLAG : ST_R_ADJ;
      end
      ST_R_ADJ: begin
        col_raddr = adj_rdata;
        state_next = ST_R_COL;
      end
      ST_R_COL: begin
        tab_raddr = {rv, col_rdata};
        state_next = ST_R_TAB;
      end
      ST_R_TAB: begin
        tab_we = 1'b1; tab_waddr = {rv, colw};
        tab_wdata = gcct_pkg::count_inc(tab_rdata);
        state_next = ST_R_WALK;
      end
      ST_R_FLAG: begin
        flg_we = 1'b1; flg_waddr = rv; flg_wdata = flag;
        state_next = (rv == '1) ? ST_F_COL : ST_R_START;
      end
      ST_M_LOOP: begin
        adj_raddr = {v, d[gcct_pkg::SLOT_W-1:0]};
        state_next = (d == degv) ? ST_W_START : ST_M_ADJ;
      end
      ST_M_ADJ: begin
        col_raddr = adj_rdata;
        state_next = ST_M_COL;
      end
      ST_M_COL: begin
        tab_raddr = {w, c};
        state_next = (prev != c) ? ST_M_UP : ST_M_CHK;
      end
      ST_M_UP: begin
        tab_we = 1'b1; tab_waddr = {w, c};
        tab_wdata = gcct_pkg::count_inc(tab_rdata);
        tab_raddr = {w, prev};
        state_next = ST_M_DN;
      end
      ST_M_DN: begin
        tab_we = 1'b1; tab_waddr = {w, prev};
        tab_wdata = gcct_pkg::count_dec(tab_rdata);
        state_next = ST_M_CHK;
      end
      ST_M_CHK: begin
        state_next = (colw == prev) ? ST_W_START : ST_M_NEW;
      end
      ST_M_WDONE: begin
        flg_raddr = w;
        state_next = wres ? ST_M_NEW : ST_M_CLR;
      end
      ST_M_CLR: begin
        flg_we = flg_rdata; flg_waddr = w; flg_wdata = 1'b0;
        state_next = ST_M_NEW;
      end
      ST_M_NEW: begin
        flg_raddr = w;
        state_next = (colw == c) ? ST_M_SET : ST_M_LOOP;
      end
      ST_M_SET: begin
        flg_we = !flg_rdata; flg_waddr = w; flg_wdata = 1'b1;
        state_next = ST_M_LOOP;
      end
      ST_M_SDONE: begin
        flg_raddr = v;
        state_next = ST_M_SFLAG;
      end
      ST_M_SFLAG: begin
        flg_we = (flg_rdata != wres); flg_waddr = v; flg_wdata = wres;
        state_next = ST_F_COL;
      end
      ST_W_START: begin
        col_raddr = wx;
        deg_raddr = wx;
        state_next = ST_W_CAP;
      end
      ST_W_CAP: begin
        state_next = ST_W_LOOP;
      end
      ST_W_LOOP: begin
        adj_raddr = {wx, e[gcct_pkg::SLOT_W-1:0]};
        state_next = (e == wdeg) ? walk_ret : ST_W_ADJ;
      end
      ST_W_ADJ: begin
        col_raddr = adj_rdata;
        state_next = ST_W_CMP;
      end
      ST_W_CMP: begin
        state_next = (col_rdata == wcol) ? walk_ret : ST_W_LOOP;
      end
      ST_F_COL: begin
        col_raddr = v;
        state_next = ST_F_OWN;
      end
      ST_F_OWN: begin
        tab_raddr = {v, col_rdata};
        state_next = ST_F_QRY;
      end
      ST_F_QRY: begin
        tab_raddr = {v, c};
        state_next = ST_F_CAP;
      end
      ST_F_CAP: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state, totals, configuration and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr        <= '0;
      num_colors <= gcct_pkg::NCOL_RESET;
      cvt        <= '0;
      cet        <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        num_colors <= cfg_wr_data;
      end
      // A finished item loads the result register once it is free.
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr <= clr + 12'd1;
        end
        ST_DISPATCH: begin
          if (op == gcct_pkg::OP_REBUILD) begin
            cvt <= '0;
          end
        end
        ST_R_FLAG: begin
          cvt <= cvt + {{(gcct_pkg::CVT_W-1){1'b0}}, flag};
          if (rv == '1) begin
            // Every undirected edge was counted from both ends.
            cet <= raw[gcct_pkg::RAW_W-1:1];
          end
        end
        ST_M_CHK: begin
          if (colw == prev && prev != c && cet != '0) begin
            cet <= cet - 12'd1;
          end
        end
        ST_M_CLR: begin
          if (flg_rdata) begin
            cvt <= cvt - 9'd1;
          end
        end
        ST_M_NEW: begin
          if (colw == c && prev != c && cet != gcct_pkg::EDGE_MAX) begin
            cet <= cet + 12'd1;
          end
        end
        ST_M_SET: begin
          if (!flg_rdata) begin
            cvt <= cvt + 9'd1;
          end
        end
        ST_M_SFLAG: begin
          if (flg_rdata != wres) begin
            cvt <= wres ? cvt + 9'd1 : cvt - 9'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers of the current item; no reset needed.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          op     <= s_tdata[2:0];
          v      <= s_tdata[10:3];
          nb     <= s_tdata[18:11];
          c      <= s_tdata[22:19];
          status <= gcct_pkg::STATUS_OK;
          d      <= '0;
        end
      end
      ST_DISPATCH: begin
        prev <= col_rdata;
        degv <= deg_rdata;
        rv   <= '0;
        raw  <= '0;
        if (op == gcct_pkg::OP_ADD_EDGE) begin
          if (deg_rdata >= gcct_pkg::DEG_FULL) begin
            status <= gcct_pkg::STATUS_FULL;
          end
        end else if (op == gcct_pkg::OP_SET || op == gcct_pkg::OP_MOVE ||
                     op == gcct_pkg::OP_QUERY) begin
          if (!c_ok) begin
            status <= gcct_pkg::STATUS_RANGE;
          end
        end
      end
      ST_R_CAP: begin
        rdeg <= deg_rdata;
        rcol <= col_rdata;
        k    <= '0;
        d    <= '0;
        flag <= 1'b0;
      end
      ST_R_CLR: begin
        k <= k + 4'd1;
      end
      ST_R_COL: begin
        colw <= col_rdata;
      end
      ST_R_TAB: begin
        if (colw == rcol) begin
          flag <= 1'b1;
          raw  <= raw + 13'd1;
        end
        d <= d + 5'd1;
      end
      ST_R_FLAG: begin
        rv <= rv + 8'd1;
      end
      ST_M_LOOP: begin
        if (d == degv) begin
          wx        <= v;
          walk_self <= 1'b1;
        end
      end
      ST_M_ADJ: begin
        w <= adj_rdata;
      end
      ST_M_COL: begin
        colw <= col_rdata;
      end
      ST_M_CHK: begin
        wx        <= w;
        walk_self <= 1'b0;
      end
      ST_M_NEW: begin
        if (colw != c) begin
          d <= d + 5'd1;
        end
      end
      ST_M_SET: begin
        d <= d + 5'd1;
      end
      ST_W_CAP: begin
        wdeg <= deg_rdata;
        wcol <= col_rdata;
        e    <= '0;
        wres <= 1'b0;
      end
      ST_W_CMP: begin
        if (col_rdata == wcol) begin
          wres <= 1'b1;
        end else begin
          e <= e + 5'd1;
        end
      end
      ST_F_QRY: begin
        own_nz <= (tab_rdata != '0);
      end
      ST_F_CAP: begin
        nc <= c_ok ? tab_rdata : '0;
      end
      ST_DONE: begin
        if (out_free) begin
          m_tdata <= {7'd0, prev, nc, (cvt == '0), own_nz, cet, status};
        end
      end
      default: begin
      end
    endcase
  end

  // No more vertices can be in conflict than exist.
  `GCCT_ASSERT_ALWAYS(a_cvt_range, cvt <= 9'(gcct_pkg::VERTICES))
  // The conflict walk never runs past the list it walks.
  `GCCT_ASSERT_IMP(a_walk_idx, state == ST_W_LOOP, e <= wdeg)
  // A rebuild count update always follows its table read.
  `GCCT_ASSERT_IMP(a_tab_after_col, state == ST_R_TAB, $past(state) == ST_R_COL)
  // A finished item always reaches the result register.
  `GCCT_ASSERT_NEXT(a_done_loads, state == ST_DONE && out_free, m_tvalid)

endmodule

>>> rtl/gcct_ram.sv
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module gcct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> tb/graph_coloring_conflict_tracker_unit_tb.sv
// ----------------------------------------------------------------------------
// Graph coloring conflict tracker testbench
// Drives edge, color, rebuild, move and query transfers under random stalls
// on both stream sides, predicts every result with an independent model of
// the adjacency lists, colors and neighbour color counts, and checks each
// output transfer field by field across several color count settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module graph_coloring_conflict_tracker_unit_tb;

  localparam int STALL_LIMIT = 200000;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] vtx;
    logic [7:0] nbr;
    logic [3:0] hue;
  } request_t;

  typedef struct {
    gcct_pkg::status_t status;
    logic [11:0]       edges;
    logic              vtx_conflict;
    logic              proper;
    logic [4:0]        hue_count;
    logic [3:0]        prev_hue;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        cfg_wr_en = 1'b0;
  logic [4:0]  cfg_wr_data = '0;

  graph_coloring_conflict_tracker_unit DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Shadow copy of the block's graph, colors and count table.
  logic [3:0] hue_of [gcct_pkg::VERTICES];
  logic [7:0] adj_list [gcct_pkg::VERTICES][gcct_pkg::MAX_DEGREE];
  int         degree [gcct_pkg::VERTICES];
  int         hue_tally [gcct_pkg::VERTICES][gcct_pkg::MAX_COLORS];
  bit         in_conflict [gcct_pkg::VERTICES];
  int         conflicted_vertices;
  int         conflict_edge_count;
  int         color_setting;

  request_t   pending_requests[$];
  request_t   in_flight;
  outcome_t   expected_outcomes[$];
  int         errors = 0;
  int         idle_pct = 19;
  int         stall_cycles = 0;

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch %s: got %0d expected %0d", field, got, want);
    errors++;
  endtask

  function automatic void add_request(request_t r);
    pending_requests.insert(pending_requests.size(), r);
  endfunction

  function automatic int hue_bound();
    return (color_setting < gcct_pkg::MAX_COLORS) ? color_setting : gcct_pkg::MAX_COLORS;
  endfunction

  function automatic void mark_conflict(int v, bit on);
    if (on && !in_conflict[v]) begin
      in_conflict[v] = 1'b1;
      conflicted_vertices++;
    end else if (!on && in_conflict[v]) begin
      in_conflict[v] = 1'b0;
      conflicted_vertices--;
    end
  endfunction

  function automatic bit shares_hue(int v);
    for (int d = 0; d < degree[v]; d++)
      if (hue_of[adj_list[v][d]] == hue_of[v]) return 1'b1;
    return 1'b0;
  endfunction

  // Full recount; each undirected edge is seen from both ends, hence the halving.
  function automatic void recount_table();
    int raw;
    int w;
    raw = 0;
    conflicted_vertices = 0;
    for (int v = 0; v < gcct_pkg::VERTICES; v++) begin
      in_conflict[v] = 1'b0;
      for (int c = 0; c < gcct_pkg::MAX_COLORS; c++) hue_tally[v][c] = 0;
    end
    for (int v = 0; v < gcct_pkg::VERTICES; v++) begin
      for (int d = 0; d < degree[v]; d++) begin
        w = int'(adj_list[v][d]);
        if (hue_of[w] == hue_of[v]) begin
          mark_conflict(v, 1'b1);
          raw++;
        end
        if (hue_tally[v][hue_of[w]] < 31) hue_tally[v][hue_of[w]]++;
      end
    end
    raw = raw / 2;
    conflict_edge_count = (raw > 4095) ? 4095 : raw;
  endfunction

  function automatic void recolor_vertex(int v, logic [3:0] to_hue);
    logic [3:0] from_hue;
    int w;
    from_hue = hue_of[v];
    hue_of[v] = to_hue;
    for (int d = 0; d < degree[v]; d++) begin
      w = int'(adj_list[v][d]);
      if (from_hue != to_hue) begin
        if (hue_tally[w][to_hue] < 31) hue_tally[w][to_hue]++;
        if (hue_tally[w][from_hue] > 0) hue_tally[w][from_hue]--;
      end
      if (hue_of[w] == from_hue) begin
        if (from_hue != to_hue && conflict_edge_count > 0) conflict_edge_count--;
        if (!shares_hue(w)) mark_conflict(w, 1'b0);
      end
      if (hue_of[w] == to_hue) begin
        if (from_hue != to_hue && conflict_edge_count < 4095) conflict_edge_count++;
        mark_conflict(w, 1'b1);
      end
    end
    mark_conflict(v, shares_hue(v));
  endfunction

  function automatic outcome_t apply_request(request_t r);
    outcome_t o;
    int v;
    bit hue_ok;
    v = int'(r.vtx);
    hue_ok = (r.hue < hue_bound());
    o.prev_hue = hue_of[v];
    o.status = gcct_pkg::STATUS_OK;
    case (r.op)
      gcct_pkg::OP_ADD_EDGE: begin
        if (degree[v] >= gcct_pkg::MAX_DEGREE) begin
          o.status = gcct_pkg::STATUS_FULL;
        end else begin
          adj_list[v][degree[v]] = r.nbr;
          degree[v]++;
        end
      end
      gcct_pkg::OP_SET: begin
        if (!hue_ok) o.status = gcct_pkg::STATUS_RANGE;
        else hue_of[v] = r.hue;
      end
      gcct_pkg::OP_REBUILD: recount_table();
      gcct_pkg::OP_MOVE: begin
        if (!hue_ok) o.status = gcct_pkg::STATUS_RANGE;
        else recolor_vertex(v, r.hue);
      end
      gcct_pkg::OP_QUERY: begin
        if (!hue_ok) o.status = gcct_pkg::STATUS_RANGE;
      end
      default: ;
    endcase
    o.edges = conflict_edge_count[11:0];
    o.vtx_conflict = (hue_tally[v][hue_of[v]] != 0);
    o.proper = (conflicted_vertices == 0);
    o.hue_count = hue_ok ? hue_tally[v][r.hue][4:0] : 5'd0;
    return o;
  endfunction

  // Input driver: predicts on every accepted transfer, then offers the next one.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        expected_outcomes.insert(expected_outcomes.size(), apply_request(in_flight));
      if (!s_tvalid || s_tready) begin
        if (pending_requests.size() > 0 && $urandom_range(99) >= idle_pct) begin
          in_flight = pending_requests.pop_front();
          s_tdata <= {1'b0, in_flight.hue, in_flight.nbr, in_flight.vtx, in_flight.op};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: each result transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_outcomes.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = expected_outcomes.pop_front();
          if (m_tdata[1:0] != want.status)
            report_mismatch("status", int'(m_tdata[1:0]), int'(want.status));
          if (m_tdata[13:2] != want.edges)
            report_mismatch("conflict_edges", int'(m_tdata[13:2]), int'(want.edges));
          if (m_tdata[14] != want.vtx_conflict)
            report_mismatch("vertex_in_conflict", int'(m_tdata[14]),
                            int'(want.vtx_conflict));
          if (m_tdata[15] != want.proper)
            report_mismatch("coloring_valid", int'(m_tdata[15]), int'(want.proper));
          if (m_tdata[20:16] != want.hue_count)
            report_mismatch("neighbours_of_color", int'(m_tdata[20:16]),
                            int'(want.hue_count));
          if (m_tdata[24:21] != want.prev_hue)
            report_mismatch("previous_color", int'(m_tdata[24:21]), int'(want.prev_hue));
        end
      end
      m_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Watchdog on cycles where neither side moves a transfer.
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic request_t make_request(logic [2:0] op, int v, int n, int c);
    request_t r;
    r.op = op;
    r.vtx = v[7:0];
    r.nbr = n[7:0];
    r.hue = c[3:0];
    return r;
  endfunction

  // Mostly a small vertex pool, so lists fill up and colors collide.
  function automatic int pick_vertex();
    return ($urandom_range(99) < 80) ? $urandom_range(23) : $urandom_range(255);
  endfunction

  function automatic int pick_hue();
    if (hue_bound() == 0 || $urandom_range(99) < 15) return $urandom_range(15);
    return $urandom_range(hue_bound() - 1);
  endfunction

  task automatic queue_random(int count);
    int sent;
    int roll;
    int a;
    int b;
    sent = 0;
    while (sent < count) begin
      roll = $urandom_range(999);
      a = pick_vertex();
      if (roll < 250) begin
        // Edges go in both directions so that the halved total stays meaningful.
        b = pick_vertex();
        add_request(make_request(gcct_pkg::OP_ADD_EDGE, a, b, $urandom_range(15)));
        add_request(make_request(gcct_pkg::OP_ADD_EDGE, b, a, $urandom_range(15)));
        sent += 2;
      end else begin
        if (roll < 400)
          add_request(make_request(gcct_pkg::OP_SET, a, $urandom_range(255), pick_hue()));
        else if (roll < 750)
          add_request(make_request(gcct_pkg::OP_MOVE, a, $urandom_range(255), pick_hue()));
        else if (roll < 930)
          add_request(make_request(gcct_pkg::OP_QUERY, a, $urandom_range(255), pick_hue()));
        else if (roll < 945)
          add_request(make_request(gcct_pkg::OP_REBUILD, a, $urandom_range(255),
                                   $urandom_range(15)));
        else
          add_request(make_request(3'($urandom_range(7, 5)), a,
                                   $urandom_range(255), $urandom_range(15)));
        sent++;
      end
    end
  endtask

  // Sampled at the falling edge, after every clocked update has settled.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_requests.size() != 0 || s_tvalid || expected_outcomes.size() != 0);
  endtask

  // Color count writes happen only while the block is idle.
  task automatic write_color_setting(logic [4:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    color_setting = int'(value);
  endtask

  initial begin
    for (int v = 0; v < gcct_pkg::VERTICES; v++) begin
      hue_of[v] = '0;
      degree[v] = 0;
      in_conflict[v] = 1'b0;
      for (int c = 0; c < gcct_pkg::MAX_COLORS; c++) hue_tally[v][c] = 0;
    end
    conflicted_vertices = 0;
    conflict_edge_count = 0;
    color_setting = int'(gcct_pkg::NCOL_RESET);
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset color count of four.
    add_request(make_request(gcct_pkg::OP_QUERY, 0, 0, 0));
    add_request(make_request(gcct_pkg::OP_ADD_EDGE, 0, 255, 15));
    add_request(make_request(gcct_pkg::OP_ADD_EDGE, 255, 0, 0));
    add_request(make_request(gcct_pkg::OP_ADD_EDGE, 0, 1, 0));
    add_request(make_request(gcct_pkg::OP_ADD_EDGE, 1, 0, 0));
    add_request(make_request(gcct_pkg::OP_REBUILD, 0, 0, 0));
    add_request(make_request(gcct_pkg::OP_QUERY, 0, 0, 0));
    add_request(make_request(gcct_pkg::OP_SET, 255, 0, 3));
    add_request(make_request(gcct_pkg::OP_SET, 0, 0, 15));
    add_request(make_request(gcct_pkg::OP_SET, 0, 0, 3));
    add_request(make_request(gcct_pkg::OP_QUERY, 0, 0, 3));
    add_request(make_request(gcct_pkg::OP_REBUILD, 255, 255, 15));
    add_request(make_request(gcct_pkg::OP_QUERY, 0, 0, 15));
    add_request(make_request(gcct_pkg::OP_MOVE, 0, 0, 3));
    add_request(make_request(gcct_pkg::OP_MOVE, 0, 0, 1));
    add_request(make_request(gcct_pkg::OP_MOVE, 1, 0, 15));
    add_request(make_request(gcct_pkg::OP_MOVE, 255, 0, 1));
    add_request(make_request(3'd5, 0, 255, 3));
    add_request(make_request(3'd6, 255, 0, 0));
    add_request(make_request(3'd7, 1, 170, 10));
    add_request(make_request(gcct_pkg::OP_QUERY, 255, 85, 1));
    wait_drained();

    write_color_setting(5'd16);
    queue_random(400);
    wait_drained();

    write_color_setting(5'd2);
    queue_random(250);
    wait_drained();

    // A stretch with no stalls on either side.
    idle_pct = 0;
    write_color_setting(5'd31);
    queue_random(250);
    wait_drained();
    idle_pct = 19;

    write_color_setting(5'd7);
    queue_random(150);
    wait_drained();

    write_color_setting(5'd0);
    queue_random(50);
    wait_drained();

    repeat (50) @(posedge clk);
    if (errors == 0 && expected_outcomes.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/gcct_pkg.sv
rtl/gcct_ram.sv
rtl/graph_coloring_conflict_tracker_unit.sv
tb/graph_coloring_conflict_tracker_unit_tb.sv
